@@ sv/npr_pkg.sv @@
// Shared types, constants and word layouts for the nearest palette recolor block.
package npr_pkg;

	localparam int PALETTE_DEPTH = 64;
	localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CNT_W = 7;
	localparam int DIST_W = 18;
	localparam int SQ_W = 16;

	// Item codes.
	localparam logic OP_RECOLOR = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Register map, byte addresses.
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-1:0] REG_ADDR_PALETTE_COUNT = 3'd0;

	// Lightness to byte: round(l * 255 / 100) as a reciprocal multiply.
	localparam int RED_X_W = 15;
	localparam int RECIP_W = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;
	localparam logic [RED_X_W-1:0] ROUND_HALF = 15'd50;
	localparam int PROD_W = RED_X_W + RECIP_W;

	typedef struct packed {
		logic [6:0] l;
		logic signed [7:0] a;
		logic signed [7:0] b;
	} lab_t;

	typedef struct packed {
		logic op;
		logic [5:0] entry_index;
		logic [6:0] pixel_l;
		logic signed [7:0] pixel_a;
		logic signed [7:0] pixel_b;
		logic [6:0] key_l;
		logic signed [7:0] key_a;
		logic signed [7:0] key_b;
		logic [6:0] repl_l;
		logic signed [7:0] repl_a;
		logic signed [7:0] repl_b;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red_byte;
		logic [7:0] green_byte;
		logic [7:0] blue_byte;
		logic [5:0] match_index;
		logic empty_palette;
	} out_word_t;

	// What moves from one cell to the next. For a load word, repl is the new
	// replacement; for a pixel word, it is the replacement of the best match so far.
	typedef struct packed {
		logic valid;
		logic op;
		logic [5:0] entry_index;
		lab_t pixel;
		lab_t key;
		lab_t repl;
		logic [DIST_W-1:0] best_d;
		logic [IDX_W-1:0] best_i;
	} stage_t;

endpackage

@@ sv/nearest_palette_recolor_top.sv @@
// Top level: register port, chain of palette cells and output register.
// A pixel word passes one register in each cell, then the output register, before it leaves.
// Throughput: one word per cycle, load or pixel, as the cell chain moves every cycle without a stall.
// A stall on the result side freezes the whole chain, which then stalls the pixel side.
// Reset clears palette_count and every valid flag; palette contents are undefined
// until loaded, and no clearing pass is run.
module nearest_palette_recolor_top import npr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	output logic pix_stall,
	input in_word_t pix_word,
	output logic res_valid,
	input logic res_stall,
	output out_word_t res_word,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	// The only register is the number of slots that take part in matching.
	// Values above PALETTE_DEPTH simply enable every cell.
	logic [CNT_W-1:0] palette_count_q;
	logic adv;
	stage_t head;
	stage_t chain [PALETTE_DEPTH+1];

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_count_q <= '0;
		end else if (psel && penable && pwrite && (paddr == REG_ADDR_PALETTE_COUNT)) begin
			palette_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr == REG_ADDR_PALETTE_COUNT) ? 32'(palette_count_q) : '0;

	// The chain moves whenever the output register is free or being emptied.
	assign adv = !res_valid || !res_stall;
	assign pix_stall = !adv;

	// Head of the chain. Load words travel down the chain in order with pixels, so
	// a pixel behind a load sees the new entry and a pixel ahead of it the old one.
	always_comb begin
		head.valid = pix_valid;
		head.op = pix_word.op;
		head.entry_index = pix_word.entry_index;
		head.pixel = '{l: pix_word.pixel_l, a: pix_word.pixel_a, b: pix_word.pixel_b};
		head.key = '{l: pix_word.key_l, a: pix_word.key_a, b: pix_word.key_b};
		head.repl = '{l: pix_word.repl_l, a: pix_word.repl_a, b: pix_word.repl_b};
		head.best_d = '0;
		head.best_i = '0;
	end

	assign chain[0] = head;

	// One cell per palette slot; cell i owns slot i.
	for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
		npr_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.cell_idx(IDX_W'(i)),
			.palette_count(palette_count_q),
			.up(chain[i]),
			.down(chain[i+1])
		);
	end

	// Load words end here; pixel words become result words.
	npr_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.palette_count(palette_count_q),
		.last(chain[PALETTE_DEPTH]),
		.res_valid(res_valid),
		.res_word(res_word)
	);

endmodule

@@ sv/npr_cell.sv @@
// One palette cell: holds one key and its replacement and updates the running best match.
module npr_cell import npr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [IDX_W-1:0] cell_idx,
	input logic [CNT_W-1:0] palette_count,
	input stage_t up,
	output stage_t down
);

	lab_t key_q;
	lab_t repl_q;
	stage_t down_q;
	stage_t nxt;
	logic signed [8:0] diff_l;
	logic signed [8:0] diff_a;
	logic signed [8:0] diff_b;
	logic [7:0] mag_l;
	logic [7:0] mag_a;
	logic [7:0] mag_b;
	logic [SQ_W-1:0] sq_l;
	logic [SQ_W-1:0] sq_a;
	logic [SQ_W-1:0] sq_b;
	logic [DIST_W-1:0] dist_sum;
	logic active;
	logic take;
	logic load_here;

	always_comb begin
		diff_l = $signed({2'b00, up.pixel.l}) - $signed({2'b00, key_q.l});
		diff_a = $signed({up.pixel.a[7], up.pixel.a}) - $signed({key_q.a[7], key_q.a});
		diff_b = $signed({up.pixel.b[7], up.pixel.b}) - $signed({key_q.b[7], key_q.b});
		mag_l = diff_l[8] ? 8'(-diff_l) : diff_l[7:0];
		mag_a = diff_a[8] ? 8'(-diff_a) : diff_a[7:0];
		mag_b = diff_b[8] ? 8'(-diff_b) : diff_b[7:0];
		sq_l = SQ_W'(mag_l) * SQ_W'(mag_l);
		sq_a = SQ_W'(mag_a) * SQ_W'(mag_a);
		sq_b = SQ_W'(mag_b) * SQ_W'(mag_b);
		dist_sum = DIST_W'(sq_l) + DIST_W'(sq_a) + DIST_W'(sq_b);
	end

	// The first cell in use always takes the pixel; later ones only on a strictly
	// smaller distance, so the lowest slot wins a tie.
	assign active = 32'(cell_idx) < 32'(palette_count);
	assign take = up.valid && (up.op == OP_RECOLOR) && active
		&& ((cell_idx == '0) || (dist_sum < up.best_d));
	assign load_here = up.valid && (up.op == OP_LOAD)
		&& (32'(up.entry_index) == 32'(cell_idx));

	always_comb begin
		nxt = up;
		if (take) begin
			nxt.best_d = dist_sum;
			nxt.best_i = cell_idx;
			nxt.repl = repl_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && load_here) begin
			key_q <= up.key;
			repl_q <= up.repl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q <= '0;
		end else if (adv) begin
			down_q <= nxt;
		end
	end

	assign down = down_q;

endmodule

@@ sv/npr_out.sv @@
// Output register: turns the winning replacement into bytes and holds the result word.
module npr_out import npr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [CNT_W-1:0] palette_count,
	input stage_t last,
	output logic res_valid,
	output out_word_t res_word
);

	logic res_valid_q;
	out_word_t res_word_q;
	out_word_t word_d;
	logic [RED_X_W-1:0] red_x;
	logic [PROD_W-1:0] red_prod;
	logic [8:0] red_q9;
	logic empty;

	assign empty = (palette_count == '0);

	// l * 255 + 50 is below 2^15; the reciprocal of 100 is exact in floor over that range.
	always_comb begin
		red_x = {last.repl.l, 8'b0} - RED_X_W'(last.repl.l) + ROUND_HALF;
		red_prod = PROD_W'(red_x) * PROD_W'(RECIP_100);
		red_q9 = red_prod[RECIP_SHIFT +: 9];
		word_d = '0;
		if (empty) begin
			word_d.empty_palette = 1'b1;
		end else begin
			word_d.red_byte = red_q9[8] ? 8'hFF : red_q9[7:0];
			word_d.green_byte = last.repl.a;
			word_d.blue_byte = last.repl.b;
			word_d.match_index = 6'(last.best_i);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_word_q <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= last.valid && (last.op == OP_RECOLOR);
		end
	end

	assign res_valid = res_valid_q;
	assign res_word = res_word_q;

endmodule

@@ sv/npr_chk.sv @@
// Port-level checker for the nearest palette recolor block, bound to the top level.
module npr_chk import npr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pix_stall,
	input logic res_valid,
	input logic res_stall,
	input out_word_t res_word,
	input logic pready
);

	// A stalled result word stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result word dropped while stalled");

	// A stalled result word does not change.
	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res_word))
		else $error("result word changed while stalled");

	// The pixel side is held back only by a stalled, full output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("pixel side stalled without a stalled result");

	// An empty palette gives all-zero bytes and slot zero.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_word.empty_palette |-> (res_word.red_byte == '0)
			&& (res_word.green_byte == '0) && (res_word.blue_byte == '0)
			&& (res_word.match_index == '0))
		else $error("empty palette result carries nonzero fields");

	// The register port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("register port not ready");

endmodule

bind nearest_palette_recolor_top npr_chk u_npr_chk (.*);

@@ verif/nearest_palette_recolor_top_test.sv @@
// Self-checking testbench for nearest_palette_recolor_top: directed palette cases, then random traffic.
module nearest_palette_recolor_top_test;
	import npr_pkg::*;

	// A pixel word passes every cell register and the output register before it leaves.
	// Load words make no result, so after the last result arrives a few may still be
	// moving down the chain. We wait for them to clear before touching the register.
	localparam int LATENCY = PALETTE_DEPTH + 1;
	localparam int FLUSH_CYCLES = LATENCY + 8;

	// The watchdog counts cycles in which no word, result or register write moves.
	// The longest honest quiet stretch is a flush plus a long sender gap, the chain
	// latency and a long result stall, so this is far above it.
	localparam int IDLE_LIMIT = 4000;

	// Start no new random phase once this many words, the fill loads included, have been taken.
	localparam int RANDOM_WORDS = 400;

	// Counts used by the first random phases: every extreme, including the values
	// above the palette depth that the block must clamp. Later phases pick at random.
	localparam int COUNT_STEPS [7] = '{64, 0, 127, 1, 65, 2, 63};

	typedef enum logic {ROW_WORD, ROW_COUNT} row_kind_t;

	// One row of the directed table: either a word for the pixel port, or a new
	// palette_count to be written once the block is idle. Where typed is set, the
	// expected color is written into the table instead of being predicted.
	typedef struct {
		row_kind_t kind;
		int unsigned count;
		in_word_t word;
		bit typed;
		out_word_t color;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	in_word_t pix_word;
	logic res_valid;
	logic res_stall;
	out_word_t res_word;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// Our own copy of the palette and the count register, updated as words are taken.
	lab_t key_palette [PALETTE_DEPTH];
	lab_t repl_palette [PALETTE_DEPTH];
	logic [CNT_W-1:0] count_shadow;

	// Colors still owed by the block, oldest first.
	out_word_t pending_colors [$];

	int error_count;
	bit no_idle;
	int stall_left;

	nearest_palette_recolor_top uut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic lab_t lab(int l, int a, int b);
		lab_t c;
		c.l = 7'(l);
		c.a = 8'(a);
		c.b = 8'(b);
		return c;
	endfunction

	function automatic out_word_t make_color(int red, int green, int blue, int slot, bit empty);
		out_word_t c;
		c.red_byte = 8'(red);
		c.green_byte = 8'(green);
		c.blue_byte = 8'(blue);
		c.match_index = 6'(slot);
		c.empty_palette = empty;
		return c;
	endfunction

	// Lightness is mostly legal, but a few values land above 100 so that the red
	// byte saturation gets exercised.
	function automatic lab_t rand_lab();
		lab_t c;
		c.l = 7'(($urandom_range(0, 7) == 0) ? $urandom_range(101, 127)
			: $urandom_range(0, 100));
		c.a = 8'($urandom_range(0, 255));
		c.b = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// Every field random, including the ones the chosen operation ignores.
	function automatic in_word_t random_word();
		logic [95:0] raw;
		raw = {$urandom(), $urandom(), $urandom()};
		return raw[$bits(in_word_t)-1:0];
	endfunction

	function automatic stim_row_t load_row(int slot, lab_t key, lab_t repl);
		stim_row_t row;
		row.kind = ROW_WORD;
		row.count = 0;
		row.word = random_word();
		row.word.op = OP_LOAD;
		row.word.entry_index = 6'(slot);
		row.word.key_l = key.l;
		row.word.key_a = key.a;
		row.word.key_b = key.b;
		row.word.repl_l = repl.l;
		row.word.repl_a = repl.a;
		row.word.repl_b = repl.b;
		row.typed = 1'b0;
		row.color = '0;
		return row;
	endfunction

	function automatic stim_row_t pixel_row(lab_t px, bit typed, out_word_t color);
		stim_row_t row;
		row.kind = ROW_WORD;
		row.count = 0;
		row.word = random_word();
		row.word.op = OP_RECOLOR;
		row.word.pixel_l = px.l;
		row.word.pixel_a = px.a;
		row.word.pixel_b = px.b;
		row.typed = typed;
		row.color = color;
		return row;
	endfunction

	function automatic stim_row_t count_row(int value);
		stim_row_t row;
		row.kind = ROW_COUNT;
		row.count = value;
		row.word = '0;
		row.typed = 1'b0;
		row.color = '0;
		return row;
	endfunction

	// Nearest key by squared distance over the slots in use, lowest slot on a tie.
	// A count above the palette depth behaves as the full depth, and a count of
	// zero gives an all-zero color with the empty flag raised.
	function automatic out_word_t recolor_pixel(in_word_t w);
		int used;
		int best_slot;
		int best_span;
		int span;
		int dl;
		int da;
		int db;
		int red;
		lab_t r;
		used = (count_shadow > PALETTE_DEPTH) ? PALETTE_DEPTH : count_shadow;
		if (used == 0)
			return make_color(0, 0, 0, 0, 1'b1);
		best_slot = 0;
		best_span = 0;
		for (int i = 0; i < used; i++) begin
			dl = int'(w.pixel_l) - int'(key_palette[i].l);
			da = int'(w.pixel_a) - int'(key_palette[i].a);
			db = int'(w.pixel_b) - int'(key_palette[i].b);
			span = dl * dl + da * da + db * db;
			if (i == 0 || span < best_span) begin
				best_span = span;
				best_slot = i;
			end
		end
		r = repl_palette[best_slot];
		// Percent to byte, rounding half up, then clipped for lightness above 100.
		red = (int'(r.l) * 255 + 50) / 100;
		if (red > 255)
			red = 255;
		return make_color(red, r.a, r.b, best_slot, 1'b0);
	endfunction

	// Called when the block takes a word: loads update the palette copy, pixels
	// queue the color they must produce.
	function automatic void take_word(in_word_t w);
		if (w.op == OP_LOAD) begin
			key_palette[w.entry_index] = lab(w.key_l, w.key_a, w.key_b);
			repl_palette[w.entry_index] = lab(w.repl_l, w.repl_a, w.repl_b);
		end else
			pending_colors.push_back(recolor_pixel(w));
	endfunction

	// Sender gaps: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Present one word and hold it until the block takes it. Valid stays high into
	// the next word when there is no gap, so it is never lowered and raised in one step.
	task automatic send_word(in_word_t w, bit typed, out_word_t color);
		int gap;
		pix_word <= w;
		pix_valid <= 1'b1;
		do @(posedge clk); while (pix_stall);
		if (typed && w.op == OP_RECOLOR)
			pending_colors.push_back(color);
		else
			take_word(w);
		gap = pick_gap();
		if (gap > 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending, wait for every owed color, then let any trailing loads clear
	// the chain so the block is fully idle.
	task automatic settle();
		pix_valid <= 1'b0;
		while (pending_colors.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	// Setup and access cycles for the write, then the same for a read back.
	task automatic write_palette_count(logic [CNT_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_ADDR_PALETTE_COUNT;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		count_shadow = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== 32'(value)) begin
			error_count++;
			$display("%0t: palette_count read back expected %0d got %0d", $time, value, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Result side: stalls of random length, mostly short with a few long ones, and
	// none at all during phases that run flat out.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			res_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
				: $urandom_range(0, 3);
			res_stall <= 1'b1;
		end else
			res_stall <= 1'b0;
	end

	// Every color the block hands over is matched against the oldest owed one.
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n === 1'b1 && res_valid && !res_stall) begin
			if (pending_colors.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result word %h", $time, res_word);
			end else begin
				want = pending_colors.pop_front();
				if (res_word.red_byte !== want.red_byte
						|| res_word.green_byte !== want.green_byte
						|| res_word.blue_byte !== want.blue_byte
						|| res_word.match_index !== want.match_index
						|| res_word.empty_palette !== want.empty_palette) begin
					error_count++;
					$display("%0t: expected rgb %h %h %h slot %0d empty %b, got rgb %h %h %h slot %0d empty %b",
						$time, want.red_byte, want.green_byte, want.blue_byte,
						want.match_index, want.empty_palette, res_word.red_byte,
						res_word.green_byte, res_word.blue_byte, res_word.match_index,
						res_word.empty_palette);
				end
			end
		end
	end

	// Watchdog: a hung block or a color that never arrives ends the run here.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall)
					|| (psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		stim_row_t directed_rows [$];
		in_word_t w;
		lab_t c;
		int sent;
		int phase;
		int used;
		int slot;

		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		pix_word <= '0;
		res_stall <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		count_shadow = '0;
		error_count = 0;
		no_idle = 1'b0;
		stall_left = 0;

		// Right after reset the count is zero: pixels must come back empty.
		directed_rows.push_back(pixel_row(lab(0, 0, 0), 1'b1, make_color(0, 0, 0, 0, 1'b1)));
		directed_rows.push_back(pixel_row(lab(127, -128, 127), 1'b1,
			make_color(0, 0, 0, 0, 1'b1)));
		// Keys at the corners of the Lab cube. Slots 0 and 2 share a key for the tie
		// case, slots 4 and 5 sit at equal distance from (50, 0, 0), and slots 3 and
		// 63 carry replacement lightness above 100.
		directed_rows.push_back(load_row(0, lab(0, -128, -128), lab(0, -128, -128)));
		directed_rows.push_back(load_row(1, lab(100, 127, 127), lab(100, 127, 127)));
		directed_rows.push_back(load_row(2, lab(0, -128, -128), lab(50, 0, -1)));
		directed_rows.push_back(load_row(3, lab(127, 0, 0), lab(127, 1, 1)));
		directed_rows.push_back(load_row(4, lab(50, 10, 0), lab(20, 5, 6)));
		directed_rows.push_back(load_row(5, lab(50, -10, 0), lab(30, 7, 8)));
		directed_rows.push_back(load_row(63, lab(60, 10, -10), lab(101, -1, 0)));
		// A single slot wins whatever the pixel, even the far corner.
		directed_rows.push_back(count_row(1));
		directed_rows.push_back(pixel_row(lab(100, 127, 127), 1'b1,
			make_color(0, 8'h80, 8'h80, 0, 1'b0)));
		directed_rows.push_back(count_row(6));
		// Identical keys in slots 0 and 2: the lower slot wins.
		directed_rows.push_back(pixel_row(lab(0, -128, -128), 1'b1,
			make_color(0, 8'h80, 8'h80, 0, 1'b0)));
		directed_rows.push_back(pixel_row(lab(100, 127, 127), 1'b1,
			make_color(255, 8'h7f, 8'h7f, 1, 1'b0)));
		// Exact hit on slot 3, whose replacement lightness saturates red.
		directed_rows.push_back(pixel_row(lab(127, 0, 0), 1'b1,
			make_color(255, 1, 1, 3, 1'b0)));
		// Distinct keys at equal distance: slot 4 wins over slot 5.
		directed_rows.push_back(pixel_row(lab(50, 0, 0), 1'b1, make_color(51, 5, 6, 4, 1'b0)));
		directed_rows.push_back(pixel_row(lab(127, 127, -128), 1'b0, '0));
		directed_rows.push_back(pixel_row(lab(0, 127, -128), 1'b0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[k]) begin
			if (directed_rows[k].kind == ROW_COUNT) begin
				settle();
				write_palette_count(CNT_W'(directed_rows[k].count));
			end else
				send_word(directed_rows[k].word, directed_rows[k].typed, directed_rows[k].color);
		end

		// Fill every slot so that no count can reach an entry never written.
		for (slot = 0; slot < PALETTE_DEPTH; slot++) begin
			w = random_word();
			w.op = OP_LOAD;
			w.entry_index = 6'(slot);
			c = rand_lab();
			{w.key_l, w.key_a, w.key_b} = c;
			c = rand_lab();
			{w.repl_l, w.repl_a, w.repl_b} = c;
			send_word(w, 1'b0, '0);
		end

		// Random phases: a new count each phase, then a mix of loads to random slots
		// and pixels. Half the pixels sit on or right next to a key in use, so exact
		// hits and near ties come up often; the rest are anywhere in the cube.
		sent = PALETTE_DEPTH;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			settle();
			no_idle = ($urandom_range(0, 4) == 0);
			write_palette_count(CNT_W'(phase < 7 ? COUNT_STEPS[phase] : $urandom_range(1, 64)));
			phase++;
			repeat ($urandom_range(20, 45)) begin
				w = random_word();
				if ($urandom_range(0, 3) == 0) begin
					w.op = OP_LOAD;
					c = rand_lab();
					{w.key_l, w.key_a, w.key_b} = c;
					c = rand_lab();
					{w.repl_l, w.repl_a, w.repl_b} = c;
				end else begin
					w.op = OP_RECOLOR;
					used = (count_shadow > PALETTE_DEPTH) ? PALETTE_DEPTH : count_shadow;
					if (used > 0 && $urandom_range(0, 1) == 1) begin
						slot = $urandom_range(0, used - 1);
						w.pixel_l = 7'(key_palette[slot].l + $urandom_range(0, 2) - 1);
						w.pixel_a = 8'(key_palette[slot].a + $urandom_range(0, 2) - 1);
						w.pixel_b = 8'(key_palette[slot].b + $urandom_range(0, 2) - 1);
					end else begin
						c = rand_lab();
						{w.pixel_l, w.pixel_a, w.pixel_b} = c;
					end
				end
				send_word(w, 1'b0, '0);
				sent++;
				// Now and then the sender holds off until the block has caught up.
				if ($urandom_range(0, 59) == 0) begin
					pix_valid <= 1'b0;
					do @(posedge clk); while (pending_colors.size() != 0);
				end
			end
		end

		settle();
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
sv/npr_pkg.sv
sv/npr_cell.sv
sv/npr_out.sv
sv/nearest_palette_recolor_top.sv
sv/npr_chk.sv
verif/nearest_palette_recolor_top_test.sv
